// ----- rtl/hspr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and fixed widths for the single-pattern Hopfield recall block.
// Used by hspr_ctrl, hspr_dp, hopfield_single_pattern_recall and the sim files; no dependencies.
package hspr_pkg;

    localparam int VEC_W       = 64;  // recalled bit vector
    localparam int VEC_IDX_W   = 6;   // bit position in the recalled vector
    localparam int LEN_W       = 7;   // vector length field
    localparam int IN_TDATA_W  = 8;   // stored_value, probe_value, padded to a byte
    localparam int OUT_TDATA_W = 72;  // recalled_bits, vector_length, recognized

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // input beat accepted
        logic start;    // last beat accepted: begin the recall sweep
        logic rd;       // read the stores at the sweep index
        logic publish;  // move the finished vector into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic rd_last;   // sweep index is at the last loaded element
        logic out_busy;  // output register holds a beat that is not taken this cycle
    } t_stat;

endpackage

// ----- rtl/hspr_ctrl.sv -----
`timescale 1ns / 1ps
// Controller for the Hopfield recall block: load, sweep, drain and publish phases.
// Depends on hspr_pkg for the command and status structs.
module hspr_ctrl
    import hspr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_last,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_SWEEP = 4'b0010,
        S_DRAIN = 4'b0100,
        S_PUB   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready    = (r_state == S_LOAD);
    assign o_cmd.load    = o_in_ready & i_in_valid;
    assign o_cmd.start   = o_in_ready & i_in_valid & i_in_last;
    assign o_cmd.rd      = (r_state == S_SWEEP);
    assign o_cmd.publish = (r_state == S_PUB) & ~i_stat.out_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (o_cmd.start) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (i_stat.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_PUB;
            end
            S_PUB: begin
                // hold until the output register can take the result
                if (!i_stat.out_busy) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/hspr_dp.sv -----
`timescale 1ns / 1ps
// Datapath for the Hopfield recall block: pattern and probe stores, running dot
// product, recalled and target vectors, output register. Depends on hspr_pkg.
module hspr_dp
    import hspr_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic signed [1:0] i_stored_value,
    input  logic signed [1:0] i_probe_value,
    output t_stat             o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [VEC_W-1:0]  o_recalled_bits,
    output logic [LEN_W-1:0]  o_vector_length,
    output logic              o_recognized
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int DOT_W = 9;   // |sum y_j*s_j| <= 2*64
    localparam int ACC_W = 13;  // s_i * (dot - self) + probe_i

    logic signed [1:0] mem_s [MAX_ELEMENTS];
    logic              mem_p [MAX_ELEMENTS];

    logic [CNT_W-1:0]        r_count;
    logic [IDX_W-1:0]        r_rd_idx;
    logic [IDX_W-1:0]        r_cmp_idx;
    logic                    r_cmp_vld;
    logic signed [1:0]       r_s_rd;
    logic                    r_p_rd;
    logic signed [DOT_W-1:0] r_dot;
    logic [VEC_W-1:0]        r_bits;
    logic [VEC_W-1:0]        r_target;
    logic                    r_out_vld;
    logic [VEC_W-1:0]        r_out_bits;
    logic [LEN_W-1:0]        r_out_len;
    logic                    r_out_rec;

    logic                    w_p_bin;
    logic                    w_s_pos;
    logic                    w_has_room;
    logic                    w_wr;
    logic [IDX_W-1:0]        w_wr_idx;
    logic signed [DOT_W-1:0] w_load_term;
    logic signed [DOT_W-1:0] w_self;
    logic signed [DOT_W:0]   w_rest;
    logic signed [ACC_W-1:0] w_prod;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_y;
    logic signed [DOT_W-1:0] w_dot_step;

    assign w_p_bin     = ~i_probe_value[1] & i_probe_value[0];
    assign w_s_pos     = ~i_stored_value[1] & i_stored_value[0];
    assign w_has_room  = (r_count < CNT_W'(MAX_ELEMENTS));
    assign w_wr        = i_cmd.load & w_has_room;
    assign w_wr_idx    = r_count[IDX_W-1:0];
    assign w_load_term = w_p_bin ? DOT_W'(i_stored_value) : '0;

    // y_i still holds its probe value here, so drop its own term from the dot product
    assign w_self = r_p_rd ? DOT_W'(r_s_rd) : '0;
    assign w_rest = (DOT_W + 1)'(r_dot) - (DOT_W + 1)'(w_self);
    assign w_prod = ACC_W'(r_s_rd) * ACC_W'(w_rest);
    assign w_acc  = w_prod + ACC_W'($signed({1'b0, r_p_rd}));
    assign w_y    = ~w_acc[ACC_W-1] & (w_acc != '0);

    always_comb begin
        w_dot_step = '0;
        if (w_y && !r_p_rd) begin
            w_dot_step = DOT_W'(r_s_rd);
        end else if (!w_y && r_p_rd) begin
            w_dot_step = -DOT_W'(r_s_rd);
        end
    end

    assign o_stat.rd_last  = ({1'b0, r_rd_idx} == (IDX_W + 1)'(r_count - CNT_W'(1)));
    assign o_stat.out_busy = r_out_vld & ~i_out_ready;

    assign o_out_valid     = r_out_vld;
    assign o_recalled_bits = r_out_bits;
    assign o_vector_length = r_out_len;
    assign o_recognized    = r_out_rec;

    // Stores: one write port while loading, one registered read port while sweeping
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem_s[w_wr_idx] <= i_stored_value;
            mem_p[w_wr_idx] <= w_p_bin;
        end
        if (i_cmd.rd) begin
            r_s_rd    <= mem_s[r_rd_idx];
            r_p_rd    <= mem_p[r_rd_idx];
            r_cmp_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            if (r_count == '0) begin
                // first beat of a vector: restart dot product and target
                r_dot    <= w_load_term;
                r_target <= VEC_W'(w_s_pos);
            end else begin
                r_dot                             <= r_dot + w_load_term;
                r_target[VEC_IDX_W'(w_wr_idx)] <= w_s_pos;
            end
        end
        if (i_cmd.start) begin
            r_bits <= '0;
        end
        if (r_cmp_vld) begin
            r_dot                           <= r_dot + w_dot_step;
            r_bits[VEC_IDX_W'(r_cmp_idx)] <= w_y;
        end
        if (i_cmd.publish) begin
            r_out_bits <= r_bits;
            r_out_len  <= LEN_W'(r_count);
            r_out_rec  <= (r_bits == r_target);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.publish) begin
                r_count <= '0;
            end else if (w_wr) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.start) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
            r_cmp_vld <= i_cmd.rd;
            if (i_cmd.publish) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (CNT_W'(r_rd_idx) < r_count))
        else $error("sweep read beyond loaded elements");

    a_pub_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |-> !r_cmp_vld && !i_cmd.rd)
        else $error("publish while an update is still in flight");

    a_no_load_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !r_cmp_vld && !i_cmd.rd)
        else $error("input beat taken during the recall sweep");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ELEMENTS))
        else $error("element count above capacity");

endmodule

// ----- rtl/hopfield_single_pattern_recall.sv -----
`timescale 1ns / 1ps
// The result beat is registered: after the last input beat the controller steps through
// sweep, drain and publish, waiting in publish while an untaken beat is held. One input
// beat per cycle while loading; the recall sweep then stalls the input and runs one
// element per cycle through the single store read port into the running dot product.
// Reset (i_rst_n, synchronous, active low) empties the vector and the output register.
module hopfield_single_pattern_recall
    import hspr_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [1:0] stored_value, [3:2] probe_value
    input  logic                   s_axis_tlast,   // last_element
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [63:0] recalled_bits,
                                                   // [70:64] vector_length, [71] recognized
);

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [VEC_W-1:0] w_bits;
    logic [LEN_W-1:0] w_len;
    logic             w_rec;

    hspr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    hspr_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_stored_value  ($signed(s_axis_tdata[1:0])),
        .i_probe_value   ($signed(s_axis_tdata[3:2])),
        .o_stat          (w_stat),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_recalled_bits (w_bits),
        .o_vector_length (w_len),
        .o_recognized    (w_rec)
    );

    assign m_axis_tdata = {w_rec, w_len, w_bits};

endmodule

// ----- sim/hspr_recall_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for hopfield_single_pattern_recall: watches the input and output streams,
// runs its own recall sweep per input vector and compares each output beat by field.
// Depends on hspr_pkg for the stream widths.
module hspr_recall_checker
    import hspr_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [1:0] stored_value, [3:2] probe_value
    input  logic                   i_s_tlast,   // last_element
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,   // [63:0] recalled_bits,
                                                // [70:64] vector_length, [71] recognized
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [VEC_W-1:0] bits;
        logic [LEN_W-1:0] len;
        logic             recog;
    } t_recall;

    int      pattern_val [MAX_ELEMENTS];
    bit      probe_bit   [MAX_ELEMENTS];
    int      loaded = 0;
    t_recall recall_q[$];
    int      fails  = 0;

    // One in-order sweep of asynchronous updates over the loaded vector.
    function automatic t_recall sweep_recall();
        bit               y [MAX_ELEMENTS];
        int               acc;
        logic [VEC_W-1:0] target;
        t_recall          r;
        r.bits = '0;
        target = '0;
        for (int i = 0; i < loaded; i++) y[i] = probe_bit[i];
        for (int i = 0; i < loaded; i++) begin
            acc = 0;
            for (int j = 0; j < loaded; j++) begin
                if (j != i) acc += int'(y[j]) * pattern_val[j] * pattern_val[i];
            end
            acc += int'(probe_bit[i]);
            y[i] = (acc > 0);
        end
        for (int i = 0; i < loaded; i++) begin
            r.bits[i] = y[i];
            target[i] = (pattern_val[i] > 0);
        end
        r.len   = LEN_W'(loaded);
        r.recog = (r.bits == target);
        return r;
    endfunction

    task automatic report(input string what, input logic [VEC_W-1:0] exp_v,
                          input logic [VEC_W-1:0] act_v);
        fails++;
        $display("%0t %s: expected %0h, actual %0h", $time, what, exp_v, act_v);
    endtask

    // Sample mid-cycle: a beat seen here is taken at the next rising edge.
    always @(negedge i_clk) begin : watch
        t_recall got;
        t_recall want;
        if (!i_rst_n) begin
            loaded = 0;
            recall_q.delete();
        end else begin
            // Check the output first so a beat can never match a vector closing now.
            if (i_m_tvalid && i_m_tready) begin
                got.bits  = i_m_tdata[VEC_W-1:0];
                got.len   = i_m_tdata[VEC_W+LEN_W-1:VEC_W];
                got.recog = i_m_tdata[VEC_W+LEN_W];
                if (recall_q.size() == 0) begin
                    report("unexpected result beat", '0, got.bits);
                end else begin
                    want = recall_q.pop_front();
                    if (got.bits !== want.bits)
                        report("recalled_bits", want.bits, got.bits);
                    if (got.len !== want.len)
                        report("vector_length", VEC_W'(want.len), VEC_W'(got.len));
                    if (got.recog !== want.recog)
                        report("recognized", VEC_W'(want.recog), VEC_W'(got.recog));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                // Drop elements past the store depth; the count saturates.
                if (loaded < MAX_ELEMENTS) begin
                    pattern_val[loaded] = $signed(i_s_tdata[1:0]);
                    probe_bit[loaded]   = !i_s_tdata[3] && i_s_tdata[2];
                    loaded++;
                end
                if (i_s_tlast) begin
                    recall_q.insert(recall_q.size(), sweep_recall());
                    loaded = 0;
                end
            end
        end
        o_fail_count = fails;
        o_pending    = recall_q.size();
    end

endmodule

// ----- sim/tb_hopfield_single_pattern_recall.sv -----
`timescale 1ns / 1ps
// Top of the recall testbench: clock, reset, input vectors and output back-pressure.
// Depends on hspr_pkg, hopfield_single_pattern_recall and hspr_recall_checker.
module tb_hopfield_single_pattern_recall;
    import hspr_pkg::*;

    localparam int MAX_ELEMENTS = 64;
    localparam int PHASE_ITEMS  = 450;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = MAX_ELEMENTS + 16;
    localparam int CYCLE_LIMIT  = 400000;

    // 2-bit signed element codes
    localparam logic [1:0] VAL_ZERO = 2'b00;
    localparam logic [1:0] VAL_POS  = 2'b01;
    localparam logic [1:0] VAL_NEG2 = 2'b10;
    localparam logic [1:0] VAL_NEG  = 2'b11;

    typedef enum int {PAT_NEAR, PAT_BIPOLAR, PAT_ANY} t_pat_mode;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    wire                    s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    wire                    m_tvalid;
    logic                   m_tready = 1'b0;
    wire  [OUT_TDATA_W-1:0] m_tdata;

    int   src_idle  = 0;
    int   sink_idle = 0;
    logic sink_hold = 1'b0;
    int   fail_count;
    int   pending;
    int   cycles    = 0;

    hopfield_single_pattern_recall #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    hspr_recall_checker #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) recall_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (sink_hold) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_idle);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Offer one beat after a random gap; return at the edge that takes it.
    task automatic send_beat(input logic [1:0] sv, input logic [1:0] pv, input logic last);
        bit took;
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-4){1'b0}}, pv, sv};
        s_tlast  <= last;
        do begin
            @(negedge i_clk);
            took = s_tready;
            @(posedge i_clk);
        end while (!took);
    endtask

    function automatic logic [1:0] pick_stored(input t_pat_mode mode);
        if (mode == PAT_ANY) return 2'($urandom_range(0, 3));
        return $urandom_range(0, 1) ? VAL_POS : VAL_NEG;
    endfunction

    // Near mode: probe is the binarized pattern with a few bits flipped.
    function automatic logic [1:0] pick_probe(input t_pat_mode mode, input logic [1:0] sv);
        bit want_one;
        if (mode != PAT_NEAR) return 2'($urandom_range(0, 3));
        want_one = (sv == VAL_POS) ^ ($urandom_range(0, 99) < 15);
        if (want_one) return VAL_POS;
        case ($urandom_range(0, 2))
            0:       return VAL_ZERO;
            1:       return VAL_NEG;
            default: return VAL_NEG2;
        endcase
    endfunction

    task automatic send_vector(input int n, input t_pat_mode mode);
        logic [1:0] sv;
        for (int k = 0; k < n; k++) begin
            sv = pick_stored(mode);
            send_beat(sv, pick_probe(mode, sv), k == n - 1);
        end
    endtask

    task automatic run_phase(input int idle_src, input int idle_snk, input bit squeeze,
                             input int long_extra);
        int        sent;
        int        n;
        int        r;
        t_pat_mode mode;
        src_idle  <= idle_src;
        sink_idle <= idle_snk;
        if (squeeze) begin
            fork
                begin
                    sink_hold <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    sink_hold <= 1'b0;
                end
            join_none
        end
        // Open with a full-depth vector, with extra beats past the store when asked.
        send_vector(MAX_ELEMENTS + long_extra, PAT_NEAR);
        sent = MAX_ELEMENTS;
        while (sent < PHASE_ITEMS) begin
            r = $urandom_range(0, 29);
            if (r == 0)     n = MAX_ELEMENTS + $urandom_range(0, 3);
            else if (r < 4) n = $urandom_range(9, 24);
            else            n = $urandom_range(1, 8);
            r = $urandom_range(0, 9);
            if (r < 5)      mode = PAT_NEAR;
            else if (r < 8) mode = PAT_BIPOLAR;
            else            mode = PAT_ANY;
            send_vector(n, mode);
            sent += (n < MAX_ELEMENTS) ? n : MAX_ELEMENTS;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-element vectors
        send_beat(VAL_POS, VAL_POS, 1'b1);
        send_beat(VAL_NEG, VAL_NEG, 1'b1);
        // the -2 code on both fields
        send_beat(VAL_NEG2, VAL_NEG2, 1'b0);
        send_beat(VAL_NEG,  VAL_ZERO, 1'b1);
        // zero stored value next to every other code
        send_beat(VAL_ZERO, VAL_POS,  1'b0);
        send_beat(VAL_POS,  VAL_NEG,  1'b0);
        send_beat(VAL_NEG,  VAL_ZERO, 1'b0);
        send_beat(VAL_NEG2, VAL_POS,  1'b1);
        // corrupted probe that the sweep should repair
        send_beat(VAL_POS, VAL_POS,  1'b0);
        send_beat(VAL_NEG, VAL_NEG,  1'b0);
        send_beat(VAL_POS, VAL_ZERO, 1'b0);
        send_beat(VAL_POS, VAL_POS,  1'b0);
        send_beat(VAL_NEG, VAL_POS,  1'b1);
        // fully inverted probe
        send_beat(VAL_POS, VAL_NEG,  1'b0);
        send_beat(VAL_POS, VAL_NEG2, 1'b0);
        send_beat(VAL_NEG, VAL_POS,  1'b0);
        send_beat(VAL_NEG, VAL_POS,  1'b1);

        run_phase(6, 88, 1'b0, 0);
        run_phase(88, 6, 1'b0, 1);
        run_phase(0, 0, 1'b1, 3);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/hspr_pkg.sv
rtl/hspr_ctrl.sv
rtl/hspr_dp.sv
rtl/hopfield_single_pattern_recall.sv
sim/hspr_recall_checker.sv
sim/tb_hopfield_single_pattern_recall.sv
